/* rtl/rwsa_pkg.sv */
package rwsa_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned ANGLE_W    = 31;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned OFS_W      = 38;   // edge and plane offsets, Q.12
  localparam int unsigned NORM_W     = 31;   // magnitudes after joint scaling
  localparam int unsigned CORD_W     = 34;   // cordic x, y, z
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CORD_STEPS = 30;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_A_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_A_HIGH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_B_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_B_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISTANCE    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_COS     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_SIN     = 3'd6;

  localparam logic [COORD_W-1:0] ROT_COS_RESET = 32'h4000_0000;

  localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [ANGLE_W-1:0]       MAX_ANGLE   = 31'd1686629713;

  typedef struct packed {
    logic [COORD_W-1:0] edge_a_low;
    logic [COORD_W-1:0] edge_a_high;
    logic [COORD_W-1:0] edge_b_low;
    logic [COORD_W-1:0] edge_b_high;
    logic [COORD_W-1:0] distance;
    logic [COORD_W-1:0] rot_cos;
    logic [COORD_W-1:0] rot_sin;
  } cfg_t;

  // offsets of one point, handed from front to back
  typedef struct packed {
    logic [OFS_W-1:0] a1;
    logic [OFS_W-1:0] a2;
    logic [OFS_W-1:0] b1;
    logic [OFS_W-1:0] b2;
    logic [OFS_W-1:0] d;
    logic             on_plane;
  } ofs_t;

  typedef struct packed {
    logic valid;
    logic on_plane;
  } side_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [CORD_W-1:0] atan_val(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

/* rtl/rwsa_if.sv */
interface rwsa_pt_if import rwsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface rwsa_res_if import rwsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] view_angle;
  logic               on_plane;
  modport source(output valid, view_angle, on_plane, input ready);
  modport sink(input valid, view_angle, on_plane, output ready);
endinterface

interface rwsa_cfg_if import rwsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [COORD_W-1:0]    data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

/* rtl/rwsa_front.sv */
module rwsa_front import rwsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rwsa_pt_if.sink      pt_i,
  input  cfg_t         cfg_regs_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output ofs_t         push_data_o
);

  logic                      en;
  logic                      s1_valid_q, s2_valid_q;
  logic signed [63:0]        pxc_q, pys_q, pyc_q;
  logic signed [63:0]        pxs;
  logic signed [64:0]        npxs_q;
  logic signed [COORD_W-1:0] pz_q;
  logic signed [OFS_W-1:0]   x0, y0, d;
  ofs_t                      ofs_d, ofs_q;

  assign en         = !s2_valid_q || push_ready_i;
  assign pt_i.ready = en;
  assign pxs        = pt_i.point_x * $signed(cfg_regs_i.rot_sin);

  // rotation products
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxc_q  <= pt_i.point_x * $signed(cfg_regs_i.rot_cos);
      pys_q  <= pt_i.point_y * $signed(cfg_regs_i.rot_sin);
      pyc_q  <= pt_i.point_y * $signed(cfg_regs_i.rot_cos);
      npxs_q <= -$signed({pxs[63], pxs});
      pz_q   <= pt_i.point_z;
    end
  end

  // floored to Q.12, then offsets
  always_comb begin
    x0 = OFS_W'(pxc_q >>> 30) + OFS_W'(pys_q >>> 30);
    y0 = OFS_W'(pyc_q >>> 30) + OFS_W'(npxs_q >>> 30);
    d  = OFS_W'($signed(cfg_regs_i.distance)) - x0;
    ofs_d.a1       = OFS_W'($signed(cfg_regs_i.edge_a_low))  - y0;
    ofs_d.a2       = OFS_W'($signed(cfg_regs_i.edge_a_high)) - y0;
    ofs_d.b1       = OFS_W'($signed(cfg_regs_i.edge_b_low))  - OFS_W'(pz_q);
    ofs_d.b2       = OFS_W'($signed(cfg_regs_i.edge_b_high)) - OFS_W'(pz_q);
    ofs_d.d        = d;
    ofs_d.on_plane = (d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ofs_q <= ofs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pt_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign push_valid_o = s2_valid_q;
  assign push_data_o  = ofs_q;

endmodule

/* rtl/rwsa_fifo.sv */
module rwsa_fifo import rwsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  ofs_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output ofs_t pop_data_o
);

  ofs_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != FIFO_PTR_W'(0) + (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

/* rtl/rwsa_corner.sv */
module rwsa_corner import rwsa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [OFS_W-1:0]         a_i,
  input  logic [OFS_W-1:0]         b_i,
  input  logic [OFS_W-1:0]         d_i,
  input  side_t                    side_i,
  output logic signed [CORD_W-1:0] ang_o,
  output side_t                    side_o
);

  localparam int unsigned LAT = 4 + SQRT_STEPS + 2 + CORD_STEPS + 1;

  side_t side_q [LAT];

  // stage 0: magnitudes and sign
  logic [OFS_W-1:0] ua0_q, ub0_q, ud0_q;
  logic             neg0_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua0_q  <= a_i[OFS_W-1] ? OFS_W'(-$signed(a_i)) : a_i;
      ub0_q  <= b_i[OFS_W-1] ? OFS_W'(-$signed(b_i)) : b_i;
      ud0_q  <= d_i[OFS_W-1] ? OFS_W'(-$signed(d_i)) : d_i;
      neg0_q <= a_i[OFS_W-1] ^ b_i[OFS_W-1] ^ d_i[OFS_W-1];
    end
  end

  // stage 1: joint scaling below 2^31
  logic [OFS_W-1:0]  or1;
  logic [2:0]        k1;
  logic [NORM_W-1:0] ua1_q, ub1_q, ud1_q;
  logic              neg1_q;
  always_comb begin
    or1 = ua0_q | ub0_q | ud0_q;
    k1  = '0;
    for (int j = NORM_W; j < OFS_W; j++) begin
      if (or1[j]) k1 = 3'(j - NORM_W + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua1_q  <= NORM_W'(ua0_q >> k1);
      ub1_q  <= NORM_W'(ub0_q >> k1);
      ud1_q  <= NORM_W'(ud0_q >> k1);
      neg1_q <= neg0_q;
    end
  end

  // stage 2: squares and a*b
  logic [61:0]       sqa2_q, sqb2_q, sqd2_q, p2_q;
  logic [NORM_W-1:0] ud2_q;
  logic              neg2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqa2_q <= ua1_q * ua1_q;
      sqb2_q <= ub1_q * ub1_q;
      sqd2_q <= ud1_q * ud1_q;
      p2_q   <= ua1_q * ub1_q;
      ud2_q  <= ud1_q;
      neg2_q <= neg1_q;
    end
  end

  // stage 3 and root steps share arrays, index 0 is the sum of squares
  logic [63:0]       sv_q   [SQRT_STEPS+1];
  logic [63:0]       sr_q   [SQRT_STEPS+1];
  logic [61:0]       sp_q   [SQRT_STEPS+1];
  logic [NORM_W-1:0] sd_q   [SQRT_STEPS+1];
  logic              sneg_q [SQRT_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0]   <= 64'(sqa2_q) + 64'(sqb2_q) + 64'(sqd2_q);
      sr_q[0]   <= '0;
      sp_q[0]   <= p2_q;
      sd_q[0]   <= ud2_q;
      sneg_q[0] <= neg2_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [64:0] trial;
    assign trial = {1'b0, sr_q[k]} + {1'b0, Bit};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, sv_q[k]} >= trial) begin
          sv_q[k+1] <= sv_q[k] - trial[63:0];
          sr_q[k+1] <= (sr_q[k] >> 1) + Bit;
        end else begin
          sv_q[k+1] <= sv_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
        sp_q[k+1]   <= sp_q[k];
        sd_q[k+1]   <= sd_q[k];
        sneg_q[k+1] <= sneg_q[k];
      end
    end
  end

  // stage 4: q = |d| * root
  logic [62:0] p4_q, q4_q;
  logic        neg4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q4_q   <= sd_q[SQRT_STEPS] * sr_q[SQRT_STEPS][31:0];
      p4_q   <= 63'(sp_q[SQRT_STEPS]);
      neg4_q <= sneg_q[SQRT_STEPS];
    end
  end

  // stage 5: scale p, q below 2^30 and seed the cordic
  logic [62:0]              or5;
  logic [5:0]               k5;
  logic [29:0]              p5, q5;
  logic signed [CORD_W-1:0] cx_q [CORD_STEPS+1];
  logic signed [CORD_W-1:0] cy_q [CORD_STEPS+1];
  logic signed [CORD_W-1:0] cz_q [CORD_STEPS+1];
  logic                     czp_q [CORD_STEPS+1];
  logic                     czq_q [CORD_STEPS+1];
  logic                     cneg_q [CORD_STEPS+1];
  always_comb begin
    or5 = p4_q | q4_q;
    k5  = '0;
    for (int j = 30; j < 63; j++) begin
      if (or5[j]) k5 = 6'(j - 29);
    end
    p5 = 30'(p4_q >> k5);
    q5 = 30'(q4_q >> k5);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]   <= $signed({4'b0, q5});
      cy_q[0]   <= $signed({4'b0, p5});
      cz_q[0]   <= '0;
      czp_q[0]  <= (p5 == '0);
      czq_q[0]  <= (q5 == '0);
      cneg_q[0] <= neg4_q;
    end
  end

  for (genvar i = 0; i < CORD_STEPS; i++) begin : g_cordic
    logic signed [CORD_W-1:0] dx, dy, at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = atan_val(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + at;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - at;
        end
        czp_q[i+1]  <= czp_q[i];
        czq_q[i+1]  <= czq_q[i];
        cneg_q[i+1] <= cneg_q[i];
      end
    end
  end

  // stage 6: special cases, clamp, sign
  logic signed [CORD_W-1:0] zf, mag6;
  always_comb begin
    zf = cz_q[CORD_STEPS];
    if (czp_q[CORD_STEPS])      mag6 = '0;
    else if (czq_q[CORD_STEPS]) mag6 = HALF_PI_Q30;
    else if (zf < 0)            mag6 = '0;
    else if (zf > HALF_PI_Q30)  mag6 = HALF_PI_Q30;
    else                        mag6 = zf;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_o <= cneg_q[CORD_STEPS] ? -mag6 : mag6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) side_q[s] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < LAT; s++) side_q[s] <= side_q[s-1];
    end
  end

  assign side_o = side_q[LAT-1];

endmodule

/* rtl/rwsa_back.sv */
module rwsa_back import rwsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  ofs_t      pop_data_i,
  rwsa_res_if.source res_o
);

  logic                     en;
  side_t                    side_in, side_out;
  logic signed [CORD_W-1:0] ang [4];
  logic signed [CORD_W+1:0] sum_q;
  side_t                    sum_side_q;
  logic [CORD_W+1:0]        mag;
  logic [CORD_W:0]          rnd;
  logic [ANGLE_W-1:0]       angle_q;
  logic                     valid_q, on_plane_q;

  assign en          = !valid_q || res_o.ready;
  assign pop_ready_o = en;
  assign side_in     = '{valid: pop_valid_i, on_plane: pop_data_i.on_plane};

  rwsa_corner u_c11 (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(pop_data_i.a1), .b_i(pop_data_i.b1), .d_i(pop_data_i.d),
    .side_i(side_in), .ang_o(ang[0]), .side_o(side_out)
  );
  rwsa_corner u_c22 (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(pop_data_i.a2), .b_i(pop_data_i.b2), .d_i(pop_data_i.d),
    .side_i('0), .ang_o(ang[1]), .side_o()
  );
  rwsa_corner u_c12 (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(pop_data_i.a1), .b_i(pop_data_i.b2), .d_i(pop_data_i.d),
    .side_i('0), .ang_o(ang[2]), .side_o()
  );
  rwsa_corner u_c21 (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(pop_data_i.a2), .b_i(pop_data_i.b1), .d_i(pop_data_i.d),
    .side_i('0), .ang_o(ang[3]), .side_o()
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= (CORD_W+2)'(ang[0]) + (CORD_W+2)'(ang[1])
             - (CORD_W+2)'(ang[2]) - (CORD_W+2)'(ang[3]);
    end
  end

  always_comb begin
    mag = sum_q[CORD_W+1] ? (CORD_W+2)'(-sum_q) : sum_q;
    rnd = (CORD_W+1)'((mag + (CORD_W+2)'(2)) >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      on_plane_q <= sum_side_q.on_plane;
      if (sum_side_q.on_plane)                 angle_q <= '0;
      else if (rnd > (CORD_W+1)'(MAX_ANGLE))   angle_q <= MAX_ANGLE;
      else                                     angle_q <= ANGLE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_side_q <= '0;
      valid_q    <= 1'b0;
    end else if (en) begin
      sum_side_q <= side_out;
      valid_q    <= sum_side_q.valid;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.view_angle = angle_q;
  assign res_o.on_plane   = on_plane_q;

endmodule

/* rtl/rectangle_window_solid_angle_top.sv */
// path from point transfer to result valid: 2 front stages, queue, 69-stage corner
//   lanes built from the 32 root steps and 30 cordic steps, sum, output register
// throughput: one point per cycle, every lane stage advances each cycle the output
//   register is free
// reset: async active low, clears valids, queue pointers and loads config defaults
//   (cosine 1.0, everything else 0)
module rectangle_window_solid_angle_top import rwsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwsa_pt_if.sink     pt_i,
  rwsa_res_if.source  res_o,
  rwsa_cfg_if.sink    cfg_i
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  ofs_t push_data, pop_data;

  // config writes are always accepted, ready is tied high
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rot_cos: ROT_COS_RESET, default: '0};
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CFG_EDGE_A_LOW:  cfg_q.edge_a_low  <= cfg_i.data;
        CFG_EDGE_A_HIGH: cfg_q.edge_a_high <= cfg_i.data;
        CFG_EDGE_B_LOW:  cfg_q.edge_b_low  <= cfg_i.data;
        CFG_EDGE_B_HIGH: cfg_q.edge_b_high <= cfg_i.data;
        CFG_DISTANCE:    cfg_q.distance    <= cfg_i.data;
        CFG_ROT_COS:     cfg_q.rot_cos     <= cfg_i.data;
        CFG_ROT_SIN:     cfg_q.rot_sin     <= cfg_i.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: rotation into the plane frame and edge offsets, flags on-plane points
  rwsa_front u_front (
    .clk_i, .rst_ni, .pt_i,
    .cfg_regs_i  (cfg_q),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // short queue lets the front keep taking points while the back stalls
  rwsa_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // back: four corner lanes, inclusion-exclusion sum, rounding, output register
  rwsa_back u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .res_o
  );

endmodule

/* rtl/rwsa_checker.sv */
module rwsa_checker import rwsa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [ANGLE_W-1:0] view_angle_i,
  input logic               on_plane_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(view_angle_i) && $stable(on_plane_i))
    else $error("result changed while stalled");

  a_plane_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && on_plane_i |-> view_angle_i == '0)
    else $error("on-plane result not zero");

  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> view_angle_i <= MAX_ANGLE)
    else $error("solid angle above two pi");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result valid right after reset");

endmodule

bind rectangle_window_solid_angle_top rwsa_checker u_rwsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .view_angle_i(res_o.view_angle),
  .on_plane_i  (res_o.on_plane)
);

/* tb/sv/tb.sv */
module tb;
  import rwsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM    = 1330;
  localparam int unsigned DRAIN_WAIT  = 120;   // beyond the pipeline depth
  localparam longint      CYCLE_LIMIT = 400000;

  // register index the block does not decode
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // ---------------------------------------------------------------------------
  // prediction: signed fixed-point geometry mirroring the block
  // ---------------------------------------------------------------------------

  typedef struct packed {
    logic [ANGLE_W-1:0] view_angle;
    logic               on_plane;
  } angle_res_t;

  typedef longint signed sl_t;
  typedef longint unsigned ul_t;

  // truncated atan(2^-i) table, Q2.30
  sl_t atan_table [CORD_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

  // floor of v / 2^s
  function automatic sl_t floor_sh(sl_t v, int s);
    return v >>> s;
  endfunction

  function automatic ul_t root64(ul_t v);
    ul_t r;
    ul_t b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(p/q), Q2.30, clamped to a quarter turn
  function automatic sl_t atan_pq(ul_t p, ul_t q);
    sl_t x;
    sl_t y;
    sl_t z;
    sl_t dx;
    sl_t dy;
    sl_t step_angle;
    while ((p | q) >= (64'd1 << 30)) begin
      p = p >> 1;
      q = q >> 1;
    end
    if (p == 0) return 0;
    if (q == 0) return sl_t'(HALF_PI_Q30);
    x = sl_t'(q);
    y = sl_t'(p);
    z = 0;
    for (int i = 0; i < CORD_STEPS; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      step_angle = sl_t'(atan_table[i]);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += step_angle;
      end else begin
        x -= dx;
        y += dy;
        z -= step_angle;
      end
    end
    if (z < 0) z = 0;
    if (z > sl_t'(HALF_PI_Q30)) z = sl_t'(HALF_PI_Q30);
    return z;
  endfunction

  function automatic ul_t magn(sl_t v);
    return (v < 0) ? ul_t'(-v) : ul_t'(v);
  endfunction

  // pyramid term for one window corner, sign of a*b*d
  function automatic sl_t corner_term(sl_t a, sl_t b, sl_t d);
    ul_t ua;
    ul_t ub;
    ul_t ud;
    ul_t m;
    sl_t ang;
    logic neg;
    ua = magn(a);
    ub = magn(b);
    ud = magn(d);
    neg = ((a < 0) ^ (b < 0)) ^ (d < 0);
    m = ua;
    if (ub > m) m = ub;
    if (ud > m) m = ud;
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      ua = ua >> 1;
      ub = ub >> 1;
      ud = ud >> 1;
    end
    ang = atan_pq(ua * ub, ud * root64(ua * ua + ub * ub + ud * ud));
    return neg ? -ang : ang;
  endfunction

  // testbench copy of the window registers
  logic signed [COORD_W-1:0] window_regs [7];

  function automatic angle_res_t window_angle(logic signed [COORD_W-1:0] px,
                                              logic signed [COORD_W-1:0] py,
                                              logic signed [COORD_W-1:0] pz);
    angle_res_t r;
    sl_t c;
    sl_t s;
    sl_t x0;
    sl_t y0;
    sl_t a1;
    sl_t a2;
    sl_t b1;
    sl_t b2;
    sl_t d;
    sl_t sum;
    ul_t mag;
    c = sl_t'(window_regs[CFG_ROT_COS]);
    s = sl_t'(window_regs[CFG_ROT_SIN]);
    x0 = floor_sh(sl_t'(px) * c, 30) + floor_sh(sl_t'(py) * s, 30);
    y0 = floor_sh(sl_t'(py) * c, 30) + floor_sh(-sl_t'(px) * s, 30);
    a1 = sl_t'(window_regs[CFG_EDGE_A_LOW]) - y0;
    a2 = sl_t'(window_regs[CFG_EDGE_A_HIGH]) - y0;
    b1 = sl_t'(window_regs[CFG_EDGE_B_LOW]) - sl_t'(pz);
    b2 = sl_t'(window_regs[CFG_EDGE_B_HIGH]) - sl_t'(pz);
    d  = sl_t'(window_regs[CFG_DISTANCE]) - x0;
    if (d == 0) begin
      r.view_angle = '0;
      r.on_plane = 1'b1;
      return r;
    end
    sum = corner_term(a1, b1, d) + corner_term(a2, b2, d)
        - corner_term(a1, b2, d) - corner_term(a2, b1, d);
    mag = (magn(sum) + 2) >> 2;
    if (mag > ul_t'(MAX_ANGLE)) mag = ul_t'(MAX_ANGLE);
    r.view_angle = mag[ANGLE_W-1:0];
    r.on_plane = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  int unsigned mismatch_count = 0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // scoreboard: angles still due from the block, oldest first
  class angle_board;
    angle_res_t due_angles [$];

    function void note_point(logic signed [COORD_W-1:0] px,
                             logic signed [COORD_W-1:0] py,
                             logic signed [COORD_W-1:0] pz);
      due_angles.push_back(window_angle(px, py, pz));
    endfunction

    task check_angle(logic [ANGLE_W-1:0] got_angle, logic got_flag);
      angle_res_t want;
      if (due_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle=%0d flag=%0b",
                                  got_angle, got_flag));
        return;
      end
      want = due_angles.pop_front();
      if (got_angle !== want.view_angle)
        report_mismatch($sformatf("view_angle got %0d want %0d",
                                  got_angle, want.view_angle));
      if (got_flag !== want.on_plane)
        report_mismatch($sformatf("on_plane got %0b want %0b",
                                  got_flag, want.on_plane));
    endtask
  endclass

  angle_board board;

  // ---------------------------------------------------------------------------
  // clock, reset, block
  // ---------------------------------------------------------------------------

  logic clk_i;
  logic rst_ni;

  rwsa_pt_if  pt_if ();
  rwsa_res_if res_if ();
  rwsa_cfg_if cfg_if ();

  rectangle_window_solid_angle_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // idle controls: 20 percent unless a calm stretch is running
  logic calm_stretch = 1'b0;

  function automatic logic idle_now();
    return !calm_stretch && ($urandom_range(99) < 20);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, check every transfer
  // ---------------------------------------------------------------------------

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) board.check_angle(res_if.view_angle, res_if.on_plane);
      res_if.ready <= !idle_now();
    end
  end

  // cycle counter and timeout
  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rectangle_window_solid_angle_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  // one register write; block must be idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx <= CFG_ROT_SIN) window_regs[idx] = val;
    cfg_if.valid <= 1'b0;
  endtask

  // one point transfer, with a random gap before it
  task automatic send_point(logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py,
                            logic signed [COORD_W-1:0] pz);
    while (idle_now()) begin
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.point_z <= pz;
    do @(posedge clk_i); while (!pt_if.ready);
    board.note_point(px, py, pz);
  endtask

  // drop valid and wait for every due angle, then let the pipe empty
  task automatic drain_block();
    pt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.due_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // random Q20.12 coordinate, mostly window-scale, sometimes any 32 bits
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return $signed($urandom_range(8191)) - 4096;
      default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_extreme();
    case ($urandom_range(4))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // window settings: edges low/high, distance, rotation
  task automatic load_window(logic signed [COORD_W-1:0] al, logic signed [COORD_W-1:0] ah,
                             logic signed [COORD_W-1:0] bl, logic signed [COORD_W-1:0] bh,
                             logic signed [COORD_W-1:0] plane_dist,
                             logic signed [COORD_W-1:0] cs, logic signed [COORD_W-1:0] sn);
    write_reg(CFG_EDGE_A_LOW, al);
    write_reg(CFG_EDGE_A_HIGH, ah);
    write_reg(CFG_EDGE_B_LOW, bl);
    write_reg(CFG_EDGE_B_HIGH, bh);
    write_reg(CFG_DISTANCE, plane_dist);
    write_reg(CFG_ROT_COS, cs);
    write_reg(CFG_ROT_SIN, sn);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    int unsigned               phase_items;

    board = new();
    for (int i = 0; i < 7; i++) window_regs[i] = '0;
    window_regs[CFG_ROT_COS] = ROT_COS_RESET;

    rst_ni        = 1'b0;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.addr   = '0;
    cfg_if.data   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window is empty at distance zero: origin lies on the plane
    send_point(0, 0, 0);
    send_point(32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000);
    drain_block();

    // a 20 mm square window 100 mm away, no rotation
    load_window(-32'sd40960, 32'sd40960, -32'sd40960, 32'sd40960, 32'sd409600,
                32'sh4000_0000, 32'sd0);
    send_point(0, 0, 0);                          // centered view
    send_point(32'sd409600, 0, 0);                // on the plane
    send_point(32'sd409599, 0, 0);                // just in front, near two pi
    send_point(32'sd409600 - 32'sd409, 32'sd40960, 32'sd40960);  // at a corner
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send_point(-32'sd1, -32'sd1, -32'sd1);
    send_point(32'sd819200, 0, 0);                // behind the plane
    send_point(0, 32'sd40960, 0);                 // on an edge line: zero product
    drain_block();

    // inverted edges and a zero-width window
    load_window(32'sd40960, -32'sd40960, 32'sd8192, 32'sd8192, -32'sd204800,
                32'sh4000_0000, 32'sd0);
    send_point(0, 0, 0);
    send_point(0, 32'sd1000, 32'sd8192);
    drain_block();
    write_reg(CFG_EDGE_B_HIGH, -32'sd40960);
    send_point(0, 0, 0);
    send_point(-32'sd204800, 0, 0);
    send_point(32'sd5000, -32'sd7000, 32'sd9000);
    drain_block();

    // rotated a quarter turn, and full-range register extremes
    load_window(-32'sd40960, 32'sd40960, -32'sd40960, 32'sd40960, 32'sd409600,
                32'sd0, 32'sh4000_0000);
    send_point(0, 0, 0);
    send_point(0, -32'sd409600, 0);               // plane offset doubles
    send_point(32'sd409600, 32'sd1000, 0);
    drain_block();
    load_window(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, -32'sh4000_0000, -32'sh4000_0000);
    send_point(0, 0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sd1, 0, 32'sd5);
    drain_block();
    // index out of range is ignored by the block
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    send_point(32'sd3, -32'sd7, 32'sd11);
    drain_block();

    // random phases: new window, then a burst of points
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) begin
        load_window(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh4000_0000, 32'sh4000_0000);
      end else if (ph % 3 == 0) begin
        load_window(rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme(),
                    rand_extreme(), $urandom(), $urandom());
      end else begin
        load_window(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000,
                    $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
      end
      calm_stretch = (ph == 4);
      phase_items = N_RANDOM / 10;
      for (int n = 0; n < phase_items; n++) begin
        px = rand_coord();
        py = rand_coord();
        pz = rand_coord();
        // some points placed exactly on the plane when unrotated
        if ($urandom_range(19) == 0 && window_regs[CFG_ROT_SIN] == 0 &&
            window_regs[CFG_ROT_COS] == 32'sh4000_0000)
          px = window_regs[CFG_DISTANCE];
        if ($urandom_range(29) == 0) px = rand_extreme();
        send_point(px, py, pz);
      end
      calm_stretch = 1'b0;
      drain_block();
    end

    // final wait, then verdict
    if (mismatch_count == 0 && board.due_angles.size() == 0) begin
      $display("rectangle_window_solid_angle_top verification clean");
    end else begin
      $display("rectangle_window_solid_angle_top verification failed");
    end
    $finish;
  end

endmodule
